// ===== rtl/core/ibp_pkg.sv =====
// ----------------------------------------------------------------------------
// ibp_pkg: shared types, constants and helpers for the band-pass filter
// Formats, register indexes, multiplier geometry and saturation functions.
// ----------------------------------------------------------------------------
package ibp_pkg;

    // field formats
    localparam int SAMPLE_WIDTH = 16;
    localparam int STATE_WIDTH  = 48;
    localparam int GAIN_WIDTH   = 48;
    localparam int TAP_WIDTH    = 32;
    localparam int GAIN_FRAC    = 24;
    localparam int TAP_FRAC     = 28;

    // filter structure
    localparam int NUM_TAPS     = 6;
    localparam int FF_REPEATS   = 3;
    localparam int TAP_IDX_W    = $clog2(NUM_TAPS);

    // configuration port
    localparam int REG_IDX_W    = 3;
    localparam int CFG_DATA_W   = (GAIN_WIDTH > TAP_WIDTH) ? GAIN_WIDTH : TAP_WIDTH;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_TAP_0 = 3'd1;

    // digit-serial multiplier geometry
    localparam int DIGIT_W      = 8;
    localparam int MPLR_MIN_W   = (TAP_WIDTH > SAMPLE_WIDTH) ? TAP_WIDTH : SAMPLE_WIDTH;
    localparam int NUM_DIGITS   = (MPLR_MIN_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MPLR_W       = NUM_DIGITS * DIGIT_W;
    localparam int DIGIT_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int MCAND_W      = (STATE_WIDTH > GAIN_WIDTH + 1) ? STATE_WIDTH
                                                                 : GAIN_WIDTH + 1;
    localparam int PROD_W       = MCAND_W + MPLR_W;

    typedef logic signed [STATE_WIDTH-1:0] t_state;
    typedef logic signed [TAP_WIDTH-1:0]   t_tap;
    typedef logic signed [PROD_W-1:0]      t_prod;

    localparam t_state STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam t_state STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    // saturating add or subtract on state values
    function automatic t_state sat_addsub(t_state a, t_state b, logic sub);
        logic signed [STATE_WIDTH:0] s;
        t_state res;
        if (sub) begin
            s = {a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b};
        end else begin
            s = {a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b};
        end
        if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
            res = s[STATE_WIDTH] ? STATE_MIN : STATE_MAX;
        end else begin
            res = s[STATE_WIDTH-1:0];
        end
        return res;
    endfunction

    // clamp a wide product to the state range
    function automatic t_state clamp_state(t_prod v);
        logic [PROD_W-STATE_WIDTH:0] upper;
        t_state res;
        upper = v[PROD_W-1:STATE_WIDTH-1];
        if ((&upper) || (~|upper)) begin
            res = v[STATE_WIDTH-1:0];
        end else if (v[PROD_W-1]) begin
            res = STATE_MIN;
        end else begin
            res = STATE_MAX;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/iir_bandpass_sixth_order.sv =====
// ----------------------------------------------------------------------------
// iir_bandpass_sixth_order: sixth-order IIR band-pass filter, fixed point
// Takes a new input beat only when idle, once the previous result is registered.
// One shared 8-bit digit-serial multiplier forms seven products in turn.
// Synchronous reset clears configuration registers, histories and control.
// ----------------------------------------------------------------------------
module iir_bandpass_sixth_order (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ibp_pkg::STATE_WIDTH-1:0]  o_filtered,
    input  logic                                    i_cfg_we,
    input  logic [ibp_pkg::REG_IDX_W-1:0]           i_cfg_index,
    input  logic [ibp_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam logic [ibp_pkg::TAP_IDX_W-1:0] LAST_TAP =
        ibp_pkg::TAP_IDX_W'(ibp_pkg::NUM_TAPS - 1);
    localparam logic [ibp_pkg::TAP_IDX_W-1:0] LAST_FF =
        ibp_pkg::TAP_IDX_W'(ibp_pkg::FF_REPEATS - 1);
    // history slots: x[n-2], x[n-4], x[n-6]
    localparam int X_N2 = 1;
    localparam int X_N4 = 3;
    localparam int X_N6 = 5;

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE, S_DIFF, S_FF_SUB, S_FF_ADD, S_FB, S_DONE
    } t_fsm;

    t_fsm                              r_state;
    logic [ibp_pkg::TAP_IDX_W-1:0]     r_step;
    logic [ibp_pkg::GAIN_WIDTH-1:0]    r_gain;
    ibp_pkg::t_tap                     r_tap [ibp_pkg::NUM_TAPS];
    ibp_pkg::t_state                   r_xh  [ibp_pkg::NUM_TAPS];
    ibp_pkg::t_state                   r_yh  [ibp_pkg::NUM_TAPS];
    ibp_pkg::t_state                   r_scaled;
    ibp_pkg::t_state                   r_d;
    ibp_pkg::t_state                   r_acc;
    ibp_pkg::t_state                   r_out;
    logic                              r_out_valid;

    logic                              accept;
    logic                              finish;
    logic                              mul_start;
    logic                              mul_done;
    logic [ibp_pkg::TAP_IDX_W-1:0]     tap_sel;
    logic [ibp_pkg::TAP_IDX_W-1:0]     y_sel;
    logic signed [ibp_pkg::MCAND_W-1:0] mcand;
    logic signed [ibp_pkg::MPLR_W-1:0]  mplr;
    ibp_pkg::t_prod                    prod;
    ibp_pkg::t_state                   alu_a;
    ibp_pkg::t_state                   alu_b;
    logic                              alu_sub;
    ibp_pkg::t_state                   alu_sum;
    ibp_pkg::t_state                   fb_term;
    ibp_pkg::t_state                   scaled_next;

    // handshakes
    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && (r_state == S_IDLE);
    assign finish     = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign o_valid    = r_out_valid;
    assign o_filtered = r_out;

    // tap selection: next tap is started while the current product is added
    always_comb begin
        if (r_state == S_FB) begin
            tap_sel = (r_step == LAST_TAP) ? r_step : r_step + 1'b1;
        end else begin
            tap_sel = '0;
        end
        y_sel = LAST_TAP - tap_sel;
    end

    assign mul_start = accept || (r_state == S_FF_SUB) ||
                       ((r_state == S_FB) && mul_done && (r_step != LAST_TAP));

    // multiplier operands: gain times sample, or past output times tap
    always_comb begin
        if (r_state == S_IDLE) begin
            mcand = ibp_pkg::MCAND_W'(r_gain);
            mplr  = ibp_pkg::MPLR_W'(i_sample);
        end else begin
            mcand = ibp_pkg::MCAND_W'(r_yh[y_sel]);
            mplr  = ibp_pkg::MPLR_W'(r_tap[tap_sel]);
        end
    end

    ibp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mcand),
        .i_mplr    (mplr),
        .o_done    (mul_done),
        .o_product (prod)
    );

    // rescale products
    assign scaled_next = ibp_pkg::clamp_state(prod >>> ibp_pkg::GAIN_FRAC);
    assign fb_term     = ibp_pkg::clamp_state(prod >>> ibp_pkg::TAP_FRAC);

    // shared saturating adder
    always_comb begin
        case (r_state)
            S_DIFF: begin
                alu_a   = r_xh[X_N4];
                alu_b   = r_xh[X_N2];
                alu_sub = 1'b1;
            end
            S_FF_SUB: begin
                alu_a   = r_scaled;
                alu_b   = r_xh[X_N6];
                alu_sub = 1'b1;
            end
            S_FB: begin
                alu_a   = r_acc;
                alu_b   = fb_term;
                alu_sub = 1'b0;
            end
            default: begin
                alu_a   = r_acc;
                alu_b   = r_d;
                alu_sub = 1'b0;
            end
        endcase
        alu_sum = ibp_pkg::sat_addsub(alu_a, alu_b, alu_sub);
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (mul_done) begin
                        r_scaled <= scaled_next;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_d     <= alu_sum;
                    r_state <= S_FF_SUB;
                end
                S_FF_SUB: begin
                    r_acc   <= alu_sum;
                    r_step  <= '0;
                    r_state <= S_FF_ADD;
                end
                S_FF_ADD: begin
                    r_acc <= alu_sum;
                    if (r_step == LAST_FF) begin
                        r_step  <= '0;
                        r_state <= S_FB;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FB: begin
                    if (mul_done) begin
                        r_acc <= alu_sum;
                        if (r_step == LAST_TAP) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (finish) begin
                        r_out       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // input and output delay lines, newest at slot 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ibp_pkg::NUM_TAPS; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else if (finish) begin
            r_xh[0] <= r_scaled;
            r_yh[0] <= r_acc;
            for (int i = 1; i < ibp_pkg::NUM_TAPS; i++) begin
                r_xh[i] <= r_xh[i-1];
                r_yh[i] <= r_yh[i-1];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            for (int i = 0; i < ibp_pkg::NUM_TAPS; i++) begin
                r_tap[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == ibp_pkg::REG_INPUT_GAIN) begin
                r_gain <= i_cfg_data[ibp_pkg::GAIN_WIDTH-1:0];
            end
            for (int i = 0; i < ibp_pkg::NUM_TAPS; i++) begin
                if (i_cfg_index == ibp_pkg::REG_FEEDBACK_TAP_0 + ibp_pkg::REG_IDX_W'(i)) begin
                    r_tap[i] <= i_cfg_data[ibp_pkg::TAP_WIDTH-1:0];
                end
            end
        end
    end

    // product completes only while the sequencer waits for it
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_SCALE || r_state == S_FB))
        else $error("multiplier done outside a wait state");

    // the result beat and both delay lines take the finished values
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_valid && (o_filtered == $past(r_acc)) &&
                    (r_yh[0] == $past(r_acc)) && (r_xh[0] == $past(r_scaled))))
        else $error("result or history not updated on finish");

    // last feedback product ends the item
    a_last_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FB) && mul_done && (r_step == LAST_TAP)) |=> (r_state == S_DONE))
        else $error("sequencer missed the last tap");

endmodule

// ===== rtl/core/ibp_mul.sv =====
// ----------------------------------------------------------------------------
// ibp_mul: digit-serial signed multiplier
// Takes the multiplier one 8-bit digit per cycle, least significant first,
// shifting finished low product bits into a shift register.
// ----------------------------------------------------------------------------
module ibp_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ibp_pkg::MCAND_W-1:0]  i_mcand,
    input  logic signed [ibp_pkg::MPLR_W-1:0]   i_mplr,
    output logic                                o_done,
    output logic signed [ibp_pkg::PROD_W-1:0]   o_product
);

    localparam int HI_W = ibp_pkg::MCAND_W + ibp_pkg::DIGIT_W + 1;

    logic signed [ibp_pkg::MCAND_W-1:0]   r_mcand;
    logic [ibp_pkg::MPLR_W-1:0]           r_mplr;
    logic signed [HI_W-1:0]               r_hi;
    logic [ibp_pkg::MPLR_W-1:0]           r_lo;
    logic [ibp_pkg::DIGIT_CNT_W-1:0]      r_cnt;
    logic                                 r_busy;
    logic                                 r_done;

    logic                                 last;
    logic signed [ibp_pkg::DIGIT_W:0]     digit;
    logic signed [HI_W-1:0]               pp;
    logic signed [HI_W-1:0]               sum;

    // current digit: top digit signed, the others unsigned
    always_comb begin
        last  = (r_cnt == ibp_pkg::DIGIT_CNT_W'(ibp_pkg::NUM_DIGITS - 1));
        digit = {last & r_mplr[ibp_pkg::DIGIT_W-1], r_mplr[ibp_pkg::DIGIT_W-1:0]};
        pp    = r_mcand * digit;
        sum   = r_hi + pp;
    end

    // digit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial product shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
            r_hi    <= '0;
            r_lo    <= '0;
        end else if (r_busy) begin
            r_hi   <= sum >>> ibp_pkg::DIGIT_W;
            r_lo   <= {sum[ibp_pkg::DIGIT_W-1:0], r_lo[ibp_pkg::MPLR_W-1:ibp_pkg::DIGIT_W]};
            r_mplr <= r_mplr >> ibp_pkg::DIGIT_W;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[ibp_pkg::MCAND_W-1:0], r_lo};

endmodule

// ===== bench/ibp_checker.sv =====
// ----------------------------------------------------------------------------
// ibp_checker: output scoreboard for the sixth-order band-pass filter
// Watches the register port and both sample channels, runs a bit-exact
// fixed-point model of the filter on every accepted input beat and compares
// each accepted output beat with the oldest predicted value.
// ----------------------------------------------------------------------------
module ibp_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] i_sample_data,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [ibp_pkg::STATE_WIDTH-1:0]  i_filtered,
    input  logic                                    i_cfg_we,
    input  logic [ibp_pkg::REG_IDX_W-1:0]           i_cfg_index,
    input  logic [ibp_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    localparam t_wide SAT_HI = (t_wide'(1) <<< (ibp_pkg::STATE_WIDTH - 1)) - 1;
    localparam t_wide SAT_LO = -SAT_HI - 1;
    localparam logic [2:0] NEWEST_SLOT = 3'd6;
    localparam int MAX_REPORTS = 10;

    // model copy of the registers and the filter state
    logic [ibp_pkg::GAIN_WIDTH-1:0] gain_reg;
    ibp_pkg::t_tap                  tap_reg [ibp_pkg::NUM_TAPS];
    ibp_pkg::t_state                scaled_ring [8];
    ibp_pkg::t_state                output_ring [8];
    logic [2:0]                     ring_pos;
    ibp_pkg::t_state                expected_filtered [$];

    // clamp a wide value to the state range
    function automatic ibp_pkg::t_state saturate(t_wide v);
        if (v > SAT_HI) begin
            return ibp_pkg::t_state'(SAT_HI[ibp_pkg::STATE_WIDTH-1:0]);
        end
        if (v < SAT_LO) begin
            return ibp_pkg::t_state'(SAT_LO[ibp_pkg::STATE_WIDTH-1:0]);
        end
        return ibp_pkg::t_state'(v[ibp_pkg::STATE_WIDTH-1:0]);
    endfunction

    function automatic ibp_pkg::t_state sat_sum(ibp_pkg::t_state a, ibp_pkg::t_state b);
        return saturate(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic ibp_pkg::t_state sat_diff(ibp_pkg::t_state a, ibp_pkg::t_state b);
        return saturate(t_wide'(a) - t_wide'(b));
    endfunction

    // floor of y * w / 2^28, saturated
    function automatic ibp_pkg::t_state tap_product(ibp_pkg::t_state y, ibp_pkg::t_tap w);
        return saturate((t_wide'(y) * t_wide'(w)) >>> ibp_pkg::TAP_FRAC);
    endfunction

    // one filter step: scale, feed-forward (1 - z^-2)^3, then feedback
    function automatic ibp_pkg::t_state filter_step(
        logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] s
    );
        t_wide           prod;
        ibp_pkg::t_state scaled;
        ibp_pkg::t_state ff_diff;
        ibp_pkg::t_state acc;
        logic [2:0]      newest;
        prod    = (t_wide'(s) * t_wide'({1'b0, gain_reg})) >>> ibp_pkg::GAIN_FRAC;
        scaled  = saturate(prod);
        newest  = ring_pos + NEWEST_SLOT;
        scaled_ring[newest] = scaled;
        acc     = sat_diff(scaled, scaled_ring[ring_pos]);
        ff_diff = sat_diff(scaled_ring[ring_pos + 3'd2], scaled_ring[ring_pos + 3'd4]);
        for (int k = 0; k < ibp_pkg::FF_REPEATS; k++) begin
            acc = sat_sum(acc, ff_diff);
        end
        // oldest output first
        for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
            acc = sat_sum(acc, tap_product(output_ring[ring_pos + 3'(k)], tap_reg[k]));
        end
        output_ring[newest] = acc;
        ring_pos = ring_pos + 3'd1;
        return acc;
    endfunction

    // register writes, prediction on input beats, compare on output beats
    always @(posedge i_clk) begin
        ibp_pkg::t_state want;
        if (!i_rst_n) begin
            gain_reg = '0;
            for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
                tap_reg[k] = '0;
            end
            for (int k = 0; k < 8; k++) begin
                scaled_ring[k] = '0;
                output_ring[k] = '0;
            end
            ring_pos = '0;
            expected_filtered.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ibp_pkg::REG_INPUT_GAIN) begin
                    gain_reg = i_cfg_data[ibp_pkg::GAIN_WIDTH-1:0];
                end else if (int'(i_cfg_index) <
                             int'(ibp_pkg::REG_FEEDBACK_TAP_0) + ibp_pkg::NUM_TAPS) begin
                    tap_reg[int'(i_cfg_index) - int'(ibp_pkg::REG_FEEDBACK_TAP_0)] =
                        ibp_pkg::t_tap'(i_cfg_data[ibp_pkg::TAP_WIDTH-1:0]);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_filtered.push_back(filter_step(i_sample_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_filtered.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("filtered beat with nothing expected: got %0d", i_filtered);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_filtered.pop_front();
                    if (i_filtered !== want) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $display("filtered mismatch: expected %0d, got %0d",
                                     want, i_filtered);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_filtered.size();
    end

endmodule

// ===== bench/tb_iir_bandpass_sixth_order.sv =====
// ----------------------------------------------------------------------------
// tb_iir_bandpass_sixth_order: stimulus and verdict for the band-pass filter
// Drives register settings from zero to the extremes, a directed set of edge
// samples and random samples under random sender gaps and receiver stalls,
// including a long output hold-off; ibp_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_iir_bandpass_sixth_order;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int STABLE_TAP_MAX  = 40265318;  // 0.15 in Q4.28

    localparam logic [ibp_pkg::REG_IDX_W-1:0] REG_OUT_OF_RANGE =
        ibp_pkg::REG_IDX_W'(int'(ibp_pkg::REG_FEEDBACK_TAP_0) + ibp_pkg::NUM_TAPS);

    localparam logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
        {1'b0, {(ibp_pkg::SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
        {1'b1, {(ibp_pkg::SAMPLE_WIDTH-1){1'b0}}};
    localparam ibp_pkg::t_tap TAP_MAX = {1'b0, {(ibp_pkg::TAP_WIDTH-1){1'b1}}};
    localparam ibp_pkg::t_tap TAP_MIN = {1'b1, {(ibp_pkg::TAP_WIDTH-1){1'b0}}};

    typedef enum int {
        MODE_STABLE,
        MODE_BUSY,
        MODE_WILD,
        MODE_TINY_GAIN,
        MODE_ALL_MAX,
        MODE_ALL_MIN,
        MODE_MIXED,
        MODE_COUNT
    } t_mode;

    logic                                    clk          = 1'b0;
    logic                                    rst_n        = 1'b0;
    logic                                    sample_valid = 1'b0;
    logic                                    sample_stall;
    logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] sample_data  = '0;
    logic                                    filtered_valid;
    logic                                    filtered_stall = 1'b0;
    logic signed [ibp_pkg::STATE_WIDTH-1:0]  filtered;
    logic                                    cfg_we       = 1'b0;
    logic [ibp_pkg::REG_IDX_W-1:0]           cfg_index    = '0;
    logic [ibp_pkg::CFG_DATA_W-1:0]          cfg_data     = '0;

    int                                      fail_count;
    int                                      pending;
    int unsigned                             quiet_cycles = 0;
    int unsigned                             hold_cycles  = 0;
    bit                                      sender_idles   = 1'b0;
    bit                                      receiver_idles = 1'b0;

    // register values for the next load
    logic [ibp_pkg::GAIN_WIDTH-1:0]          gain_set;
    ibp_pkg::t_tap                           tap_set [ibp_pkg::NUM_TAPS];

    always #6 clk = ~clk;

    iir_bandpass_sixth_order u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (sample_valid),
        .o_stall     (sample_stall),
        .i_sample    (sample_data),
        .o_valid     (filtered_valid),
        .i_stall     (filtered_stall),
        .o_filtered  (filtered),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ibp_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (sample_valid),
        .i_in_stall    (sample_stall),
        .i_sample_data (sample_data),
        .i_out_valid   (filtered_valid),
        .i_out_stall   (filtered_stall),
        .i_filtered    (filtered),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            4, 5, 6: return ibp_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 511)) - 256);
            default: return ibp_pkg::SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // taps whose magnitudes sum below one keep the loop bounded
    function automatic ibp_pkg::t_tap stable_tap();
        ibp_pkg::t_tap mag;
        mag = ibp_pkg::t_tap'($urandom_range(0, STABLE_TAP_MAX));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [ibp_pkg::GAIN_WIDTH-1:0] random_gain();
        return ibp_pkg::GAIN_WIDTH'({$urandom, $urandom});
    endfunction

    // one input beat, optionally after an idle gap
    task automatic send_sample(input logic signed [ibp_pkg::SAMPLE_WIDTH-1:0] value);
        int unsigned gap;
        gap = sender_idles ? idle_length() : 0;
        if (gap != 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= value;
        do @(posedge clk); while (sample_stall);
    endtask

    // stop sending and wait until every predicted output has come back
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write every register, plus the unused index; spare data bits are random
    task automatic load_config();
        logic [ibp_pkg::CFG_DATA_W-1:0] word;
        for (int r = 0; r <= int'(REG_OUT_OF_RANGE); r++) begin
            word = ibp_pkg::CFG_DATA_W'({$urandom, $urandom});
            if (r == int'(ibp_pkg::REG_INPUT_GAIN)) begin
                word = gain_set;
            end else if (r < int'(REG_OUT_OF_RANGE)) begin
                word[ibp_pkg::TAP_WIDTH-1:0] =
                    tap_set[r - int'(ibp_pkg::REG_FEEDBACK_TAP_0)];
            end
            cfg_we    <= 1'b1;
            cfg_index <= ibp_pkg::REG_IDX_W'(r);
            cfg_data  <= word;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_config(input t_mode mode);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        gain_set       = random_gain();
        for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
            tap_set[k] = stable_tap();
        end
        case (mode)
            MODE_BUSY: begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            MODE_WILD: begin
                for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
                    tap_set[k] = ibp_pkg::t_tap'($urandom);
                end
            end
            MODE_TINY_GAIN: begin
                gain_set       = ibp_pkg::GAIN_WIDTH'($urandom_range(0, 1 << 20));
                receiver_idles = 1'b0;
            end
            MODE_ALL_MAX: begin
                gain_set     = '1;
                sender_idles = 1'b0;
                for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
                    tap_set[k] = TAP_MAX;
                end
            end
            MODE_ALL_MIN: begin
                gain_set = '1;
                for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
                    tap_set[k] = TAP_MIN;
                end
            end
            MODE_MIXED: begin
                gain_set[ibp_pkg::GAIN_WIDTH-1] = 1'b1;
                for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
                    case ($urandom_range(0, 3))
                        0: tap_set[k] = TAP_MAX;
                        1: tap_set[k] = TAP_MIN;
                        2: tap_set[k] = '0;
                        default: tap_set[k] = ibp_pkg::t_tap'($urandom);
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    // output side: long hold-off on request, random stalls otherwise
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_cycles != 0) begin
                filtered_stall <= 1'b1;
                hold_cycles--;
            end else if (stall_left != 0) begin
                filtered_stall <= 1'b1;
                stall_left--;
            end else begin
                filtered_stall <= 1'b0;
                if (receiver_idles && $urandom_range(0, 3) == 0) begin
                    stall_left = idle_length();
                end
            end
        end
    end

    // give up when no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (sample_valid && !sample_stall) || (filtered_valid && !filtered_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_iir_bandpass_sixth_order failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: zero gain, output stays zero
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        settle();

        // full gain, mild feedback, spare bits set in tap writes
        gain_set = '1;
        for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
            tap_set[k] = '0;
        end
        tap_set[0]                     = 32'hFC00_0000;
        tap_set[ibp_pkg::NUM_TAPS - 1] = 32'h0800_0000;
        load_config();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        settle();

        // extreme taps drive the feedback products into saturation both ways
        for (int k = 0; k < ibp_pkg::NUM_TAPS; k++) begin
            tap_set[k] = TAP_MAX;
        end
        tap_set[2] = TAP_MIN;
        tap_set[4] = TAP_MIN;
        load_config();
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);
        settle();

        // random phases, one register setting each
        for (int ph = 0; ph < int'(MODE_COUNT); ph++) begin
            pick_config(t_mode'(ph));
            load_config();
            if (t_mode'(ph) == MODE_BUSY) begin
                hold_cycles = HOLD_CYCLES;
            end
            repeat (ITEMS_PER_PHASE) send_sample(random_sample());
            settle();
        end

        if (fail_count == 0) begin
            $display("tb_iir_bandpass_sixth_order passed");
        end else begin
            $display("tb_iir_bandpass_sixth_order failed");
        end
        $finish;
    end

endmodule
